FILE: hw/rtl/segment_set_intersections_core_defines.svh
// assertion macros for the segment set intersection core
`ifndef SEGMENT_SET_INTERSECTIONS_CORE_DEFINES_SVH
`define SEGMENT_SET_INTERSECTIONS_CORE_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define SSI_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication checked outside reset
`define SSI_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: hw/rtl/ssi_pkg.sv
// types and constants for the segment set intersection core
package ssi_pkg;
  typedef struct packed {
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
    logic               final_segment;
  } ssi_in_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic               point_valid;
    logic               last_point;
  } ssi_out_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SORT_CMP, ST_SORT_MOVE, ST_SWEEP_EV, ST_PAIR_SEL, ST_MUL, ST_CHECK,
    ST_INTERP_MUL, ST_DIV, ST_INTERP_END, ST_DUP, ST_EMIT, ST_EMIT_NONE
  } ssi_state_t;

  localparam int QUOT_BITS = 64;
endpackage

FILE: hw/rtl/segment_set_intersections_core.sv
// segment set intersection core: sweep over stored segments with shared multiply and divide
//
//  channel | ports                  | handshake
//  input   | in_data                | start && !busy
//  result  | out_data               | out_strobe, one cycle, no stall
//
// a segment without the final flag is stored and the core stays idle
// the final segment runs an insertion sort over 2n events, one compare per cycle
// apart from a move state per shifted event; each tested pair takes a select state,
// six multiply products and a check, and a hit adds two 128-step divides
// plus a duplicate scan over the kept points
// results leave one per cycle; synchronous reset clears counts and the sequencer
`include "segment_set_intersections_core_defines.svh"
module segment_set_intersections_core
  import ssi_pkg::*;
#(
  parameter int MAX_SEGMENTS = 8,
  parameter int COORD_BITS   = 16,
  parameter int MAX_POINTS   = 28
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  ssi_in_t  in_data,
  output logic     out_strobe,
  output ssi_out_t out_data
);
  localparam int CB   = (COORD_BITS < 16) ? COORD_BITS : 16;
  localparam int SB   = $clog2(MAX_SEGMENTS);
  localparam int CNTB = $clog2(MAX_SEGMENTS + 1);
  localparam int NEV  = 2 * MAX_SEGMENTS;
  localparam int EB   = $clog2(NEV);
  localparam int ECB  = $clog2(NEV + 1);
  localparam int PB   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int PCB  = $clog2(MAX_POINTS + 1);

  // segment store: ux, uy, lx, ly
  logic signed [16:0] seg_ux_r [MAX_SEGMENTS];
  logic signed [16:0] seg_uy_r [MAX_SEGMENTS];
  logic signed [16:0] seg_lx_r [MAX_SEGMENTS];
  logic signed [16:0] seg_ly_r [MAX_SEGMENTS];
  logic [EB-1:0]      ev_r     [NEV];
  logic [31:0]        pt_x_r   [MAX_POINTS];
  logic [31:0]        pt_y_r   [MAX_POINTS];

  ssi_state_t state_r, state_nxt;
  logic [CNTB-1:0] seg_cnt_r;
  logic [MAX_SEGMENTS-1:0] active_r;
  logic [PCB-1:0]  pt_cnt_r, pk_r;
  logic [ECB-1:0]  si_r, sj_r;
  logic [EB-1:0]   se_r;
  logic [SB-1:0]   sa_r, sb_r;
  logic [CNTB-1:0] pj_r;
  logic [2:0]      mstep_r;
  logic signed [35:0] den_r, tn_r, un_r;
  logic signed [17:0] d1x_r, d1y_r;
  logic            axis_r;
  logic [127:0]    dividend_r;
  logic [36:0]     div_d_r;
  logic [36:0]     rem_r;
  logic [QUOT_BITS-1:0] quot_r;
  logic [6:0]      dcnt_r;
  logic signed [31:0] px_r, py_r;
  logic signed [35:0] mul_acc_r;

  // sign-extend input coordinates from the configured width to 17 bits
  function automatic logic signed [16:0] sx(input logic [15:0] v);
    logic [15:0] t;
    t = v;
    for (int b = 0; b < 16; b++) if (b >= CB) t[b] = v[CB-1];
    return {t[15], t};
  endfunction

  logic signed [16:0] ix1, iy1, ix2, iy2;
  logic swap;
  assign ix1 = sx(in_data.start_x);
  assign iy1 = sx(in_data.start_y);
  assign ix2 = sx(in_data.end_x);
  assign iy2 = sx(in_data.end_y);
  assign swap = (iy1 < iy2) || (iy1 == iy2 && ix1 > ix2);

  logic accept;
  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // event coordinates for the sort compare
  logic [EB-1:0] ev_e, ev_f;
  logic signed [16:0] xe, ye, xf, yf;
  logic ev_lt;
  assign ev_e = se_r;
  assign ev_f = ev_r[sj_r[EB-1:0] - 1'b1];
  assign xe = ev_e[0] ? seg_lx_r[ev_e[EB-1:1]] : seg_ux_r[ev_e[EB-1:1]];
  assign ye = ev_e[0] ? seg_ly_r[ev_e[EB-1:1]] : seg_uy_r[ev_e[EB-1:1]];
  assign xf = ev_f[0] ? seg_lx_r[ev_f[EB-1:1]] : seg_ux_r[ev_f[EB-1:1]];
  assign yf = ev_f[0] ? seg_ly_r[ev_f[EB-1:1]] : seg_uy_r[ev_f[EB-1:1]];
  always_comb begin
    if (ye != yf)             ev_lt = ye > yf;
    else if (xe != xf)        ev_lt = xe < xf;
    else if (ev_e[0] != ev_f[0]) ev_lt = !ev_e[0];
    else                      ev_lt = ev_e[EB-1:1] < ev_f[EB-1:1];
  end

  // shared multiplier operands, one product per cycle
  logic signed [17:0] ma, mb;
  logic signed [35:0] prod;
  logic signed [17:0] d2x, d2y, ddx, ddy, a_d1x, a_d1y;
  assign a_d1x = 18'(seg_lx_r[sa_r]) - 18'(seg_ux_r[sa_r]);
  assign a_d1y = 18'(seg_ly_r[sa_r]) - 18'(seg_uy_r[sa_r]);
  assign d2x = 18'(seg_lx_r[sb_r]) - 18'(seg_ux_r[sb_r]);
  assign d2y = 18'(seg_ly_r[sb_r]) - 18'(seg_uy_r[sb_r]);
  assign ddx = 18'(seg_ux_r[sb_r]) - 18'(seg_ux_r[sa_r]);
  assign ddy = 18'(seg_uy_r[sb_r]) - 18'(seg_uy_r[sa_r]);
  always_comb begin
    case (mstep_r)
      3'd0: begin ma = a_d1x; mb = d2y; end
      3'd1: begin ma = a_d1y; mb = d2x; end
      3'd2: begin ma = ddx;   mb = d2y; end
      3'd3: begin ma = ddy;   mb = d2x; end
      3'd4: begin ma = ddx;   mb = a_d1y; end
      default: begin ma = ddy; mb = a_d1x; end
    endcase
  end
  assign prod = ma * mb;

  // normalized signs after the pair products
  logic signed [35:0] den_n, tn_n, un_n;
  assign den_n = den_r[35] ? -den_r : den_r;
  assign tn_n  = den_r[35] ? -tn_r  : tn_r;
  assign un_n  = den_r[35] ? -un_r  : un_r;
  logic hit;
  assign hit = (den_r != '0) && !tn_n[35] && (tn_n <= den_n) && !un_n[35] && (un_n <= den_n);

  // interpolation setup for the current axis
  logic signed [17:0] dsel;
  logic [17:0] dmag;
  logic [53:0] tprod;
  logic [127:0] dvd_init;
  assign dsel = axis_r ? d1y_r : d1x_r;
  assign dmag = dsel[17] ? 18'(-dsel) : 18'(dsel);
  assign tprod = 54'(tn_n) * 54'(dmag);
  assign dvd_init = ({74'd0, tprod} << 17) + (dsel[17] ? 128'(den_n - 1) : 128'(den_n));

  // restoring divider step
  logic [37:0] rem_sh;
  logic        ge;
  assign rem_sh = {rem_r, dividend_r[127]};
  assign ge = rem_sh >= {1'b0, div_d_r};

  logic signed [48:0] total;
  logic signed [31:0] sat;
  logic signed [16:0] a1sel;
  assign a1sel = axis_r ? seg_uy_r[sa_r] : seg_ux_r[sa_r];
  assign total = (49'(a1sel) <<< 16) + (dsel[17] ? -49'(quot_r) : 49'(quot_r));
  assign sat = (total > 49'sd2147483647) ? 32'sh7fffffff :
               (total < -49'sd2147483648) ? 32'sh80000000 : 32'(total);

  // only kept entries below the point count take part in the duplicate scan
  logic dup_hit;
  assign dup_hit = (pk_r != pt_cnt_r) &&
                   (pt_x_r[pk_r[PB-1:0]] == px_r) && (pt_y_r[pk_r[PB-1:0]] == py_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:
        if (accept && in_data.final_segment)
          state_nxt = (seg_cnt_r + (seg_cnt_r < CNTB'(MAX_SEGMENTS)) >= CNTB'(2)) ?
                      ST_SORT_CMP : ST_EMIT_NONE;
      ST_SORT_CMP:
        if (si_r == ECB'(2 * seg_cnt_r)) state_nxt = ST_SWEEP_EV;
        else if (sj_r != '0 && ev_lt) state_nxt = ST_SORT_MOVE;
      ST_SORT_MOVE: state_nxt = ST_SORT_CMP;
      ST_SWEEP_EV:
        if (si_r == ECB'(2 * seg_cnt_r))
          state_nxt = (pt_cnt_r == '0) ? ST_EMIT_NONE : ST_EMIT;
        else if (!ev_r[si_r[EB-1:0]][0]) state_nxt = ST_PAIR_SEL;
      ST_PAIR_SEL:
        if (pj_r == seg_cnt_r) state_nxt = ST_SWEEP_EV;
        else if (pj_r[SB-1:0] != sa_r && active_r[pj_r[SB-1:0]]) state_nxt = ST_MUL;
      ST_MUL: if (mstep_r == 3'd5) state_nxt = ST_CHECK;
      ST_CHECK: state_nxt = hit ? ST_INTERP_MUL : ST_PAIR_SEL;
      ST_INTERP_MUL: state_nxt = ST_DIV;
      ST_DIV: if (dcnt_r == 7'd127) state_nxt = ST_INTERP_END;
      ST_INTERP_END: state_nxt = axis_r ? ST_DUP : ST_INTERP_MUL;
      ST_DUP:
        if (pk_r == pt_cnt_r || dup_hit) state_nxt = ST_PAIR_SEL;
      ST_EMIT: if (pk_r + 1'b1 == pt_cnt_r) state_nxt = ST_IDLE;
      ST_EMIT_NONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // control counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_cnt_r <= '0;
      active_r  <= '0;
      pt_cnt_r  <= '0;
    end else begin
      case (state_r)
        ST_IDLE:
          if (accept && seg_cnt_r < CNTB'(MAX_SEGMENTS)) seg_cnt_r <= seg_cnt_r + 1'b1;
        ST_SWEEP_EV:
          if (si_r != ECB'(2 * seg_cnt_r) && ev_r[si_r[EB-1:0]][0])
            active_r[ev_r[si_r[EB-1:0]][EB-1:1]] <= 1'b0;
        ST_PAIR_SEL:
          if (pj_r == seg_cnt_r) active_r[sa_r] <= 1'b1;
        ST_DUP:
          if (pk_r == pt_cnt_r && pt_cnt_r < PCB'(MAX_POINTS))
            pt_cnt_r <= pt_cnt_r + 1'b1;
        ST_EMIT, ST_EMIT_NONE:
          if (state_nxt == ST_IDLE) begin
            seg_cnt_r <= '0;
            active_r  <= '0;
            pt_cnt_r  <= '0;
          end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (accept && seg_cnt_r < CNTB'(MAX_SEGMENTS)) begin
          seg_ux_r[seg_cnt_r[SB-1:0]] <= swap ? ix2 : ix1;
          seg_uy_r[seg_cnt_r[SB-1:0]] <= swap ? iy2 : iy1;
          seg_lx_r[seg_cnt_r[SB-1:0]] <= swap ? ix1 : ix2;
          seg_ly_r[seg_cnt_r[SB-1:0]] <= swap ? iy1 : iy2;
        end
        si_r <= '0;
        sj_r <= '0;
        se_r <= '0;
        pk_r <= '0;
      end
      ST_SORT_CMP: begin
        if (si_r != ECB'(2 * seg_cnt_r)) begin
          if (!(sj_r != '0 && ev_lt)) begin
            ev_r[sj_r[EB-1:0]] <= se_r;
            si_r <= si_r + 1'b1;
            sj_r <= si_r + 1'b1;
            se_r <= EB'(si_r + 1'b1);
          end
        end else begin
          si_r <= '0;
        end
      end
      ST_SORT_MOVE: begin
        ev_r[sj_r[EB-1:0]] <= ev_f;
        sj_r <= sj_r - 1'b1;
      end
      ST_SWEEP_EV: begin
        if (si_r != ECB'(2 * seg_cnt_r)) begin
          sa_r <= ev_r[si_r[EB-1:0]][EB-1:1];
          pj_r <= '0;
          si_r <= si_r + 1'b1;
        end
        pk_r <= '0;
      end
      ST_PAIR_SEL: begin
        sb_r    <= pj_r[SB-1:0];
        mstep_r <= '0;
        pj_r    <= pj_r + 1'b1;
      end
      ST_MUL: begin
        mstep_r <= mstep_r + 1'b1;
        case (mstep_r)
          3'd0, 3'd2, 3'd4: mul_acc_r <= prod;
          3'd1: den_r <= mul_acc_r - prod;
          3'd3: tn_r  <= mul_acc_r - prod;
          default: un_r <= mul_acc_r - prod;
        endcase
        d1x_r <= a_d1x;
        d1y_r <= a_d1y;
        axis_r <= 1'b0;
      end
      ST_INTERP_MUL: begin
        dividend_r <= dvd_init;
        div_d_r    <= {den_n, 1'b0};
        rem_r      <= '0;
        quot_r     <= '0;
        dcnt_r     <= '0;
      end
      ST_DIV: begin
        rem_r      <= 37'(ge ? rem_sh - {1'b0, div_d_r} : rem_sh);
        dividend_r <= dividend_r << 1;
        quot_r     <= {quot_r[QUOT_BITS-2:0], ge};
        dcnt_r     <= dcnt_r + 1'b1;
      end
      ST_INTERP_END: begin
        if (axis_r) py_r <= sat;
        else        px_r <= sat;
        axis_r <= 1'b1;
        pk_r   <= '0;
      end
      ST_DUP: begin
        if (pk_r == pt_cnt_r && pt_cnt_r < PCB'(MAX_POINTS)) begin
          pt_x_r[pk_r[PB-1:0]] <= px_r;
          pt_y_r[pk_r[PB-1:0]] <= py_r;
        end
        if (pk_r != pt_cnt_r && !dup_hit) pk_r <= pk_r + 1'b1;
      end
      ST_EMIT: pk_r <= pk_r + 1'b1;
      default: ;
    endcase
  end

  // result port
  always_comb begin
    out_strobe = 1'b0;
    out_data   = '0;
    if (state_r == ST_EMIT) begin
      out_strobe           = 1'b1;
      out_data.point_x     = pt_x_r[pk_r[PB-1:0]];
      out_data.point_y     = pt_y_r[pk_r[PB-1:0]];
      out_data.point_valid = 1'b1;
      out_data.last_point  = (pk_r + 1'b1 == pt_cnt_r);
    end else if (state_r == ST_EMIT_NONE) begin
      out_strobe          = 1'b1;
      out_data.last_point = 1'b1;
    end
  end

  `SSI_ASSERT_IMP(a_strobe_busy, out_strobe, busy, "result strobe while idle")
  `SSI_ASSERT_NXT(a_last_idle, out_strobe && out_data.last_point, !busy,
                  "core stays busy after last result")
  `SSI_ASSERT_IMP(a_pt_bound, 1'b1, pt_cnt_r <= PCB'(MAX_POINTS), "point count overflow")
  `SSI_ASSERT_NXT(a_final_busy, accept && in_data.final_segment, busy,
                  "core idle after final segment")
endmodule
